[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/srdc_pkg.sv]
// Types and constants of the sliding range distinct counter.
`default_nettype none
package srdc_pkg;

  localparam int unsigned POS_W    = 12;
  localparam int unsigned VAL_W    = 12;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned STATUS_W = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LOAD_REFUSE = 2'd2;

  typedef struct packed {
    logic             command;
    logic [POS_W-1:0] element_position;
    logic [VAL_W-1:0] element_value;
    logic [POS_W-1:0] range_left;
    logic [POS_W-1:0] range_right;
    logic [TAG_W-1:0] query_tag;
  } req_t;

  typedef struct packed {
    logic [TAG_W-1:0]    answer_tag;
    logic [CNT_W-1:0]    distinct_count;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage
`default_nettype wire

[hdl/srdc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module srdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[hdl/sliding_range_distinct_counter.sv]
// Top level of the sliding range distinct counter.
`default_nettype none
// Loads write one element each and give their status in the cycle after acceptance; busy
// stays low, so loads can follow every cycle. A query moves the window one element per step,
// and each step passes through the states S_PLAN, S_ELEM and S_CNT (element store read, count
// store read, count write-back) with busy high; a refused query answers in the cycle after
// acceptance. Answers are shown for a single cycle on done_o and cannot be held off. After
// reset the block clears every entry of the occurrence count store with busy high; configuration
// writes are taken at any time and should only be made while the block is idle.
module sliding_range_distinct_counter #(
  parameter int unsigned MAX_ELEMENTS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  srdc_pkg::req_t            req_i,
  output logic                      done_o,
  output srdc_pkg::rsp_t            rsp_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [srdc_pkg::LEN_W-1:0] cfg_data_i
);
  import srdc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PLAN,
    S_ELEM,
    S_CNT
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     clr_q;
  logic [LEN_W-1:0]  length_q;
  logic [POS_W-1:0]  wl_q;
  logic [CNT_W-1:0]  we_q;
  logic [CNT_W-1:0]  distinct_q;
  logic [POS_W-1:0]  left_q;
  logic [CNT_W-1:0]  end_q;
  logic [TAG_W-1:0]  tag_q;
  logic              add_q;
  logic [AW-1:0]     val_q;

  logic              accept;
  logic [31:0]       len_eff;
  logic              bad_range;
  logic              load_refuse;

  logic              mv_valid;
  logic              mv_add;
  logic [CNT_W-1:0]  mv_pos;
  logic [POS_W-1:0]  wl_n;
  logic [CNT_W-1:0]  we_n;

  logic              elem_we;
  logic [VAL_W-1:0]  elem_rdata;
  logic              cnt_we;
  logic [AW-1:0]     cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CNT_W-1:0]  cnt_rdata;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  assign len_eff = (32'(length_q) > 32'(MAX_ELEMENTS)) ? 32'(MAX_ELEMENTS) : 32'(length_q);
  assign bad_range = (req_i.range_left > req_i.range_right) ||
                     (32'(req_i.range_right) >= len_eff);
  assign load_refuse = (we_q != '0) ||
                       (32'(req_i.element_position) >= 32'(MAX_ELEMENTS)) ||
                       (32'(req_i.element_value) >= 32'(MAX_ELEMENTS));

  // The window grows on the right, then on the left, then shrinks on the right, then the left.
  always_comb begin
    mv_valid = 1'b1;
    mv_add   = 1'b1;
    mv_pos   = we_q;
    wl_n     = wl_q;
    we_n     = we_q;
    priority if (we_q < end_q) begin
      we_n = we_q + 13'd1;
    end else if (wl_q > left_q) begin
      wl_n   = wl_q - 12'd1;
      mv_pos = {1'b0, wl_q - 12'd1};
    end else if (we_q > end_q) begin
      mv_add = 1'b0;
      we_n   = we_q - 13'd1;
      mv_pos = we_q - 13'd1;
    end else if (wl_q < left_q) begin
      mv_add = 1'b0;
      wl_n   = wl_q + 12'd1;
      mv_pos = {1'b0, wl_q};
    end else begin
      mv_valid = 1'b0;
    end
  end

  assign elem_we = (state_q == S_IDLE) && accept && (req_i.command == CMD_LOAD) && !load_refuse;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = val_q;
    cnt_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
      end
      S_CNT: begin
        cnt_we    = add_q || (cnt_rdata != '0);
        cnt_wdata = add_q ? cnt_rdata + 13'd1 : cnt_rdata - 13'd1;
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  srdc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (AW'(req_i.element_position)),
    .wdata_i (req_i.element_value),
    .raddr_i (AW'(mv_pos)),
    .rdata_o (elem_rdata)
  );

  srdc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (AW'(elem_rdata)),
    .rdata_o (cnt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      length_q   <= LEN_RESET;
      wl_q       <= '0;
      we_q       <= '0;
      distinct_q <= '0;
      left_q     <= '0;
      end_q      <= '0;
      tag_q      <= '0;
      add_q      <= 1'b0;
      val_q      <= '0;
      done_o     <= 1'b0;
      rsp_o      <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        length_q <= cfg_data_i;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_ELEMENTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (req_i.command == CMD_LOAD) begin
              done_o               <= 1'b1;
              rsp_o.answer_tag     <= '0;
              rsp_o.distinct_count <= '0;
              rsp_o.status         <= load_refuse ? ST_LOAD_REFUSE : ST_OK;
            end else if (bad_range) begin
              done_o               <= 1'b1;
              rsp_o.answer_tag     <= req_i.query_tag;
              rsp_o.distinct_count <= '0;
              rsp_o.status         <= ST_BAD_RANGE;
            end else begin
              left_q  <= req_i.range_left;
              end_q   <= {1'b0, req_i.range_right} + 13'd1;
              tag_q   <= req_i.query_tag;
              state_q <= S_PLAN;
              if (we_q == '0) begin
                wl_q <= req_i.range_left;
                we_q <= {1'b0, req_i.range_left};
              end
            end
          end
        end
        S_PLAN: begin
          if (mv_valid) begin
            add_q   <= mv_add;
            wl_q    <= wl_n;
            we_q    <= we_n;
            state_q <= S_ELEM;
          end else begin
            done_o               <= 1'b1;
            rsp_o.answer_tag     <= tag_q;
            rsp_o.distinct_count <= distinct_q;
            rsp_o.status         <= ST_OK;
            state_q              <= S_IDLE;
          end
        end
        S_ELEM: begin
          val_q   <= AW'(elem_rdata);
          state_q <= S_CNT;
        end
        S_CNT: begin
          if (add_q) begin
            if (cnt_rdata == '0) begin
              distinct_q <= distinct_q + 13'd1;
            end
          end else if ((cnt_rdata == 13'd1) && (distinct_q != '0)) begin
            distinct_q <= distinct_q - 13'd1;
          end
          state_q <= S_PLAN;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/srdc_checker.sv]
// Port-level checker of the sliding range distinct counter and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module srdc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input srdc_pkg::req_t              req_i,
  input logic                        done_o,
  input srdc_pkg::rsp_t              rsp_o
);
  import srdc_pkg::*;

  `ASSERT_NXT(a_load_answers_next, clk_i, rst_ni, start && !busy && req_i.command == CMD_LOAD, done_o && rsp_o.answer_tag == '0 && rsp_o.distinct_count == '0 && rsp_o.status != ST_BAD_RANGE)
  `ASSERT_NXT(a_query_busy_or_done, clk_i, rst_ni, start && !busy && req_i.command == CMD_QUERY, done_o || busy)
  `ASSERT_IMP(a_done_when_idle, clk_i, rst_ni, done_o, !busy)
  `ASSERT_IMP(a_refused_count_zero, clk_i, rst_ni, done_o && rsp_o.status != ST_OK, rsp_o.distinct_count == '0)

endmodule

bind sliding_range_distinct_counter srdc_checker u_srdc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
`default_nettype wire

[test/distinct_count_checker.sv]
// Checker that predicts and compares the answers of the sliding range distinct counter.
module distinct_count_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  srdc_pkg::req_t            req_i,
  input  logic                      done_o,
  input  srdc_pkg::rsp_t            rsp_o,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_o,
  input  logic [srdc_pkg::LEN_W-1:0] cfg_data_i,
  output int unsigned               mismatches,
  output int unsigned               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import srdc_pkg::*;

  localparam int unsigned DEPTH = 4096;

  logic [VAL_W-1:0] element_copy [DEPTH];
  logic [CNT_W-1:0] value_hits [DEPTH];
  logic [CNT_W-1:0] distinct_now;
  logic [POS_W-1:0] span_start;
  logic [LEN_W-1:0] span_stop;
  logic [LEN_W-1:0] length_now;
  rsp_t             expected_answers [$];

  function automatic void count_in(int unsigned pos);
    logic [VAL_W-1:0] v;
    v = element_copy[pos];
    if (value_hits[v] == '0) distinct_now++;
    value_hits[v]++;
  endfunction

  function automatic void count_out(int unsigned pos);
    logic [VAL_W-1:0] v;
    v = element_copy[pos];
    if (value_hits[v] != '0) begin
      value_hits[v]--;
      if (value_hits[v] == '0 && distinct_now != '0) distinct_now--;
    end
  endfunction

  function automatic rsp_t answer_for(req_t r);
    rsp_t        a;
    int unsigned lim;
    int unsigned stop;
    a = '0;
    lim = (32'(length_now) > DEPTH) ? DEPTH : 32'(length_now);
    if (r.command == CMD_LOAD) begin
      if (span_stop != '0) begin
        a.status = ST_LOAD_REFUSE;
      end else begin
        element_copy[r.element_position] = r.element_value;
        a.status = ST_OK;
      end
      return a;
    end
    a.answer_tag = r.query_tag;
    if (r.range_left > r.range_right || 32'(r.range_right) >= lim) begin
      a.status = ST_BAD_RANGE;
      return a;
    end
    stop = 32'(r.range_right) + 32'd1;
    if (span_stop == '0) begin
      span_start = r.range_left;
      span_stop = LEN_W'(r.range_left);
    end
    // The window grows before it shrinks, so no count ever drops below zero.
    while (32'(span_stop) < stop) begin
      count_in(32'(span_stop));
      span_stop++;
    end
    while (span_start > r.range_left) begin
      span_start--;
      count_in(32'(span_start));
    end
    while (32'(span_stop) > stop) begin
      span_stop--;
      count_out(32'(span_stop));
    end
    while (span_start < r.range_left) begin
      count_out(32'(span_start));
      span_start++;
    end
    a.distinct_count = distinct_now;
    a.status = ST_OK;
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      foreach (element_copy[i]) element_copy[i] = '0;
      foreach (value_hits[i]) value_hits[i] = '0;
      distinct_now = '0;
      span_start = '0;
      span_stop = '0;
      length_now = LEN_RESET;
      expected_answers.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) length_now = cfg_data_i;
      if (done_o) begin
        if (expected_answers.size() == 0) begin
          $error("answer with no request waiting: answer_tag %0d", rsp_o.answer_tag);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          if (rsp_o.answer_tag !== want.answer_tag) begin
            $error("answer_tag: expected %0d, actual %0d", want.answer_tag, rsp_o.answer_tag);
            mismatches++;
          end
          if (rsp_o.distinct_count !== want.distinct_count) begin
            $error("distinct_count: expected %0d, actual %0d",
                   want.distinct_count, rsp_o.distinct_count);
            mismatches++;
          end
          if (rsp_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_o.status);
            mismatches++;
          end
        end
      end
      if (start && !busy) expected_answers = {expected_answers, answer_for(req_i)};
      outstanding <= expected_answers.size();
    end
  end

endmodule

[test/sliding_range_distinct_counter_test.sv]
// Top of the sliding range distinct counter test: clock, reset, requests and the verdict.
module sliding_range_distinct_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srdc_pkg::*;

  localparam int unsigned LOADED       = 384;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam int unsigned PHASE_COUNT  = 8;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  req_t             req_i = '0;
  logic             done_o;
  rsp_t             rsp_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LEN_W-1:0] cfg_data_i = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned len_now = 4096;
  int          span_l = 0;
  int          span_r = 0;

  sliding_range_distinct_counter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  distinct_count_checker answer_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic req_t random_fields();
    req_t r;
    r.command = 1'($urandom_range(0, 1));
    r.element_position = POS_W'($urandom_range(0, 4095));
    r.element_value = VAL_W'($urandom_range(0, 4095));
    r.range_left = POS_W'($urandom_range(0, 4095));
    r.range_right = POS_W'($urandom_range(0, 4095));
    r.query_tag = TAG_W'($urandom_range(0, 65535));
    return r;
  endfunction

  function automatic req_t make_load(logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    req_t r;
    r = random_fields();
    r.command = CMD_LOAD;
    r.element_position = pos;
    r.element_value = val;
    return r;
  endfunction

  function automatic req_t make_query(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                                      logic [TAG_W-1:0] tag);
    req_t r;
    r = random_fields();
    r.command = CMD_QUERY;
    r.range_left = lo;
    r.range_right = hi;
    r.query_tag = tag;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] element_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return VAL_W'($urandom_range(0, 31));
    if (pick < 90) return VAL_W'($urandom_range(0, LOADED - 1));
    return VAL_W'($urandom_range(0, 4095));
  endfunction

  // Mostly small moves of both window ends, as a block-ordered query stream would give.
  function automatic req_t next_query();
    req_t r;
    int   lim;
    int   pick;
    int   nl;
    int   nr;
    int   t;
    r = random_fields();
    r.command = CMD_QUERY;
    lim = (len_now < LOADED) ? len_now : LOADED;
    pick = $urandom_range(0, 99);
    if (lim == 0 || pick < 12) begin
      if (len_now <= 4095 && $urandom_range(0, 1) == 1) begin
        r.range_right = POS_W'($urandom_range(len_now, 4095));
        r.range_left = POS_W'($urandom_range(0, r.range_right));
      end else begin
        r.range_left = POS_W'($urandom_range(1, 4095));
        r.range_right = POS_W'($urandom_range(0, r.range_left - 1));
      end
      return r;
    end
    if (pick < 20) begin
      nl = $urandom_range(0, lim - 1);
      nr = $urandom_range(0, lim - 1);
    end else begin
      nl = span_l + int'($urandom_range(0, 16)) - 8;
      nr = span_r + int'($urandom_range(0, 16)) - 8;
    end
    if (nl < 0) nl = 0;
    if (nr < 0) nr = 0;
    if (nl > lim - 1) nl = lim - 1;
    if (nr > lim - 1) nr = lim - 1;
    if (nl > nr) begin
      t = nl;
      nl = nr;
      nr = t;
    end
    span_l = nl;
    span_r = nr;
    r.range_left = POS_W'(nl);
    r.range_right = POS_W'(nr);
    return r;
  endfunction

  task automatic issue_request(input req_t r);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    len_now = (v > 13'd4096) ? 32'd4096 : 32'(v);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [LEN_W-1:0] phase_len [PHASE_COUNT];
    int unsigned      idle_pct [4];
    phase_len = '{LEN_W'(LOADED), 13'd4096, 13'd57, 13'd8191, 13'd1, 13'd200, 13'd0,
                  13'd4095};
    idle_pct = '{0, 49, 0, 26};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_length(13'd8191);

    sender_idle_pct = 26;
    issue_request(make_load(12'd4095, 12'd4095));
    issue_request(make_load(12'd2048, 12'd2048));
    issue_request(make_load(12'd0, 12'd0));
    for (int p = 0; p < LOADED; p++) issue_request(make_load(POS_W'(p), element_sample()));
    for (int k = 0; k < 40; k++) begin
      issue_request(make_load(POS_W'($urandom_range(0, LOADED - 1)), element_sample()));
    end

    issue_request(make_query(12'd0, 12'd0, 16'h0000));
    issue_request(make_query(12'd0, POS_W'(LOADED - 1), 16'hFFFF));
    issue_request(make_query(POS_W'(LOADED - 1), POS_W'(LOADED - 1), 16'h8001));
    issue_request(make_query(12'd5, 12'd3, 16'h0101));
    issue_request(make_query(12'd4095, 12'd0, 16'h7FFE));
    issue_request(make_query(12'd100, 12'd120, 16'h1234));
    issue_request(make_query(12'd90, 12'd130, 16'h4321));
    issue_request(make_query(12'd110, 12'd115, 16'hAAAA));
    issue_request(make_query(12'd140, 12'd160, 16'h5555));
    issue_request(make_query(12'd20, 12'd30, 16'h0F0F));
    issue_request(make_load(12'd4095, 12'd4095));
    issue_request(make_load(12'd0, 12'd0));
    span_l = 20;
    span_r = 30;

    settle();
    write_length(13'd0);
    issue_request(make_query(12'd0, 12'd0, 16'h00F0));
    settle();
    write_length(13'd1);
    issue_request(make_query(12'd0, 12'd0, 16'h0F00));
    issue_request(make_query(12'd0, 12'd1, 16'hF000));
    settle();
    write_length(13'd4095);
    issue_request(make_query(12'd0, 12'd4095, 16'hBEEF));
    issue_request(make_query(12'd10, 12'd12, 16'h0042));

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      write_length(phase_len[ph]);
      sender_idle_pct = idle_pct[ph % 4];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 3) begin
          issue_request(make_load(POS_W'($urandom_range(0, 4095)),
                                  VAL_W'($urandom_range(0, 4095))));
        end else begin
          issue_request(next_query());
        end
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
